// ----- rtl/last_note_priority_stack_assert.svh -----
// Assertion macros shared by the last-note priority stack RTL.
`ifndef LAST_NOTE_PRIORITY_STACK_ASSERT_SVH
`define LAST_NOTE_PRIORITY_STACK_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LNPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LNPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lnps_pkg.sv -----
// Types and constants of the last-note priority stack.
package lnps_pkg;

	localparam int LNPS_STACK_DEPTH = 16;
	localparam int LNPS_CMD_DEPTH   = 2;
	localparam int LNPS_RES_DEPTH   = 4;
	localparam int LNPS_KEY_W       = 7;

	typedef logic [LNPS_KEY_W-1:0] key_t;

	typedef enum logic {
		OP_PRESS   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic {
		EV_ON  = 1'b0,
		EV_OFF = 1'b1
	} ev_t;

	typedef struct packed {
		op_t  op;
		key_t key;
		logic repressed;
	} in_word_t;

	typedef struct packed {
		ev_t  event_kind;
		key_t out_key;
		logic out_repressed;
		logic last;
	} out_word_t;

	typedef struct packed {
		op_t  kind;
		key_t key;
		logic rep;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,
		ST_SHIFT,
		ST_PUSH,
		ST_NOTEON,
		ST_RDTOP
	} state_t;

endpackage

// ----- rtl/lnps_fifo.sv -----
// Small first-in first-out queue of words, used between the block's parts.
module lnps_fifo
	import lnps_pkg::*;
#(
	parameter type word_t = logic,
	parameter int  DEPTH  = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  word_t din,
	output logic  full,
	input  logic  pop,
	output word_t dout,
	output logic  empty,
	output logic  room2
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW = AW + 1;

	word_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW-1:0] level;

	assign level = wr_ptr_q - rd_ptr_q;
	assign full  = (level == PW'(DEPTH));
	assign empty = (level == '0);
	assign room2 = (level <= PW'(DEPTH - 2));
	assign dout  = mem_q[rd_ptr_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q[AW-1:0]] <= din;
		end
	end

endmodule

// ----- rtl/lnps_front.sv -----
// Front end: takes key events, turns them into stack commands and queues them.
module lnps_front
	import lnps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_word_t item,
	output logic     full,
	input  logic     cmd_pop,
	output cmd_t     cmd,
	output logic     cmd_valid
);

	cmd_t cmd_in;
	logic cmd_empty;

	// The re-press flag only means something on a press.
	always_comb begin
		cmd_in.kind = item.op;
		cmd_in.key  = item.key;
		cmd_in.rep  = (item.op == OP_PRESS) && item.repressed;
	end

	lnps_fifo #(
		.word_t (cmd_t),
		.DEPTH  (LNPS_CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (cmd),
		.empty  (cmd_empty),
		.room2  ()
	);

	assign cmd_valid = !cmd_empty;

endmodule

// ----- rtl/lnps_engine.sv -----
// Back end: keeps the held-key stack in a memory and emits note on and off words.
module lnps_engine
	import lnps_pkg::*;
#(
	parameter int STACK_DEPTH = LNPS_STACK_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  logic      cmd_valid,
	output logic      cmd_pop,
	input  logic      res_room2,
	output logic      res_push,
	output out_word_t res_word
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	key_t          mem_q [STACK_DEPTH];
	key_t          rd_data_s1;

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] idx_q, idx_d;
	key_t          key_q, key_d;
	logic          rep_q, rep_d;
	op_t           kind_q, kind_d;
	key_t          top_q, top_d;

	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	key_t          wr_data;
	logic [AW-1:0] last_idx;
	logic          stack_full;

	assign last_idx   = AW'(count_q - CW'(1));
	assign stack_full = (count_q == CW'(STACK_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		key_q  <= key_d;
		rep_q  <= rep_d;
		kind_q <= kind_d;
		top_q  <= top_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem_q[rd_addr];
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		key_d    = key_q;
		rep_d    = rep_q;
		kind_d   = kind_q;
		top_d    = top_q;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_data  = rd_data_s1;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res_word = '{event_kind: EV_OFF, out_key: key_q, out_repressed: 1'b0, last: 1'b0};

		unique case (state_q)
			ST_IDLE: begin
				// A command starts only when the result queue has room for two words, the most that a command emits.
				if (cmd_valid && res_room2) begin
					cmd_pop = 1'b1;
					key_d   = cmd.key;
					rep_d   = cmd.rep;
					kind_d  = cmd.kind;
					idx_d   = '0;
					if (cmd.kind == OP_PRESS) begin
						if (stack_full) begin
							// Drop the oldest entry by moving everything down one place.
							rd_addr = AW'(1);
							state_d = ST_SHIFT;
						end else begin
							state_d = ST_PUSH;
						end
					end else if (count_q != '0) begin
						rd_addr = '0;
						state_d = ST_SRCH;
					end
				end
			end
			ST_SRCH: begin
				if (rd_data_s1 == key_q) begin
					if (idx_q == last_idx) begin
						count_d           = count_q - CW'(1);
						res_push          = 1'b1;
						res_word.last     = (count_q == CW'(1));
						if (count_q != CW'(1)) begin
							rd_addr = AW'(count_q - CW'(2));
							state_d = ST_RDTOP;
						end else begin
							state_d = ST_IDLE;
						end
					end else begin
						rd_addr = idx_q + AW'(1);
						state_d = ST_SHIFT;
					end
				end else if (idx_q == last_idx) begin
					state_d = ST_IDLE;
				end else begin
					rd_addr = idx_q + AW'(1);
					idx_d   = idx_q + AW'(1);
				end
			end
			ST_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = rd_data_s1;
				if ((idx_q + AW'(1)) == last_idx) begin
					count_d = count_q - CW'(1);
					state_d = (kind_q == OP_PRESS) ? ST_PUSH : ST_IDLE;
				end else begin
					rd_addr = idx_q + AW'(2);
					idx_d   = idx_q + AW'(1);
				end
			end
			ST_PUSH: begin
				wr_en   = 1'b1;
				wr_addr = AW'(count_q);
				wr_data = key_q;
				count_d = count_q + CW'(1);
				if (count_q != '0) begin
					res_push         = 1'b1;
					res_word.out_key = top_q;
				end
				state_d = ST_NOTEON;
			end
			ST_NOTEON: begin
				res_push = 1'b1;
				res_word = '{event_kind: EV_ON, out_key: key_q, out_repressed: rep_q,
					last: 1'b1};
				top_d    = key_q;
				state_d  = ST_IDLE;
			end
			ST_RDTOP: begin
				res_push = 1'b1;
				res_word = '{event_kind: EV_ON, out_key: rd_data_s1, out_repressed: 1'b0,
					last: 1'b1};
				top_d    = rd_data_s1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/last_note_priority_stack.sv -----
// Top level of the monophonic last-note priority stack.
// A word's first result reaches the result ports through the command queue, the engine and the result queue.
// A press runs the idle, push and note-on states, with a shift pass first when the stack is full.
// A release runs a search, then a shift or a read of the new top.
// Reset clears the queues, the held count and the engine state; the stack memory is not cleared.
`include "last_note_priority_stack_assert.svh"

module last_note_priority_stack
	import lnps_pkg::*;
#(
	parameter int STACK_DEPTH = LNPS_STACK_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  in_word_t  item,
	output logic      full,
	input  logic      pop,
	output out_word_t result,
	output logic      empty
);

	cmd_t      cmd;
	logic      cmd_valid;
	logic      cmd_pop;
	logic      res_push;
	out_word_t res_word;
	logic      res_full;
	logic      res_room2;

	lnps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.cmd_valid (cmd_valid)
	);

	lnps_engine #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.res_room2 (res_room2),
		.res_push  (res_push),
		.res_word  (res_word)
	);

	lnps_fifo #(
		.word_t (out_word_t),
		.DEPTH  (LNPS_RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_word),
		.full   (res_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty),
		.room2  (res_room2)
	);

	// A word is never lost to a full result queue.
	`LNPS_ASSERT_NOW(a_res_no_overflow, res_push, !res_full, "result word pushed into a full queue")
	`LNPS_ASSERT_NOW(a_cmd_room, cmd_pop, res_room2, "command taken without room for two results")
	// The first of two results is always followed at once by the second.
	`LNPS_ASSERT_NEXT(a_pair_follows, res_push && !res_word.last, res_push && res_word.last,
		"second result word did not follow")

endmodule
